@@ design/tcch_pkg.sv @@
// shared types, constants and tables for the tilt compensated compass heading block
package tcch_pkg;

  localparam int NumCfg = 6;
  localparam int CfgIdxW = 3;
  localparam int DefCordicSteps = 16;
  localparam int AtanLen = 32;
  localparam int FifoDepth = 4;

  localparam logic [CfgIdxW-1:0] RegMinX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxZ = 3'd5;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic [15:0] heading_centideg;
    logic        degenerate;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;
  } cal_t;

  // front to back: north vector
  typedef struct packed {
    logic signed [50:0] nx;
    logic signed [50:0] ny;
    logic signed [50:0] nz;
  } north_t;

  // atan(2^-i) in degrees times 65536
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0: v = 22'd2949120;  5'd1: v = 22'd1740967;
      5'd2: v = 22'd919879;   5'd3: v = 22'd466945;
      5'd4: v = 22'd234379;   5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;    5'd7: v = 22'd29335;
      5'd8: v = 22'd14668;    5'd9: v = 22'd7334;
      5'd10: v = 22'd3667;    5'd11: v = 22'd1833;
      5'd12: v = 22'd917;     5'd13: v = 22'd458;
      5'd14: v = 22'd229;     5'd15: v = 22'd115;
      5'd16: v = 22'd57;      5'd17: v = 22'd29;
      5'd18: v = 22'd14;      5'd19: v = 22'd7;
      5'd20: v = 22'd4;       5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/tcch_front.sv @@
// front pipeline: hard-iron correction and the two cross products
module tcch_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tcch_pkg::in_word_t in_word,
  input  tcch_pkg::cal_t    cal,
  output logic              out_valid,
  output tcch_pkg::north_t  out_north
);
  import tcch_pkg::*;

  // stage 1: offsets
  logic               v1;
  logic signed [17:0] mx1, my1, mz1;
  logic signed [15:0] ax1, ay1, az1;
  // stage 2: products for E
  logic               v2;
  logic signed [34:0] p2 [6];
  logic signed [15:0] ax2, ay2, az2;
  // stage 3: E
  logic               v3;
  logic signed [35:0] ex3, ey3, ez3;
  logic signed [15:0] ax3, ay3, az3;
  // stage 4: products for N
  logic               v4;
  logic signed [51:0] q4 [6];

  logic signed [16:0] offx, offy, offz;
  logic signed [16:0] sx, sy, sz;

  function automatic logic signed [16:0] half_tz(input logic signed [16:0] s);
    logic signed [16:0] t;
    t = s + {16'd0, s[16]};
    return t >>> 1;
  endfunction

  always_comb begin
    sx = 17'(cal.min_x) + 17'(cal.max_x);
    sy = 17'(cal.min_y) + 17'(cal.max_y);
    sz = 17'(cal.min_z) + 17'(cal.max_z);
    offx = half_tz(sx);
    offy = half_tz(sy);
    offz = half_tz(sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    mx1 <= 18'(in_word.mag_x) - 18'(offx);
    my1 <= 18'(in_word.mag_y) - 18'(offy);
    mz1 <= 18'(in_word.mag_z) - 18'(offz);
    ax1 <= in_word.accel_x; ay1 <= in_word.accel_y; az1 <= in_word.accel_z;

    p2[0] <= my1 * az1; p2[1] <= mz1 * ay1;
    p2[2] <= mz1 * ax1; p2[3] <= mx1 * az1;
    p2[4] <= mx1 * ay1; p2[5] <= my1 * ax1;
    ax2 <= ax1; ay2 <= ay1; az2 <= az1;

    ex3 <= 36'(p2[0]) - 36'(p2[1]);
    ey3 <= 36'(p2[2]) - 36'(p2[3]);
    ez3 <= 36'(p2[4]) - 36'(p2[5]);
    ax3 <= ax2; ay3 <= ay2; az3 <= az2;

    q4[0] <= ay3 * ez3; q4[1] <= az3 * ey3;
    q4[2] <= az3 * ex3; q4[3] <= ax3 * ez3;
    q4[4] <= ax3 * ey3; q4[5] <= ay3 * ex3;

    out_north.nx <= 51'(q4[0] - q4[1]);
    out_north.ny <= 51'(q4[2] - q4[3]);
    out_north.nz <= 51'(q4[4] - q4[5]);
  end
endmodule

@@ design/tcch_fifo.sv @@
// small queue between the front and back pipelines
module tcch_fifo #(
  parameter int Width = 8,
  parameter int Depth = tcch_pkg::FifoDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [Width-1:0] rdata,
  output logic [$clog2(Depth+1)-1:0] count
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth+1);
  logic [Width-1:0] mem [Depth];
  logic [AW-1:0] wptr, rptr;
  logic do_push, do_pop;
  // head word lives in rdata; the array only holds the words behind it
  logic head_valid, need_load, mem_empty, to_mem;

  assign full = (count == CW'(Depth));
  assign empty = !head_valid;
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;
  assign need_load = !head_valid || do_pop;
  assign mem_empty = (count == CW'(head_valid));
  // a word goes straight to the head when the head frees up and the array is empty
  assign to_mem = do_push && !(need_load && mem_empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0; head_valid <= 1'b0;
    end else begin
      if (to_mem) wptr <= (wptr == AW'(Depth-1)) ? '0 : wptr + 1'b1;
      if (need_load && !mem_empty) rptr <= (rptr == AW'(Depth-1)) ? '0 : rptr + 1'b1;
      if (need_load) head_valid <= !mem_empty || do_push;
      count <= count + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end

  // array write and registered read into the head
  always_ff @(posedge clk) begin
    if (to_mem) mem[wptr] <= wdata;
    if (need_load) begin
      if (!mem_empty) rdata <= mem[rptr];
      else if (do_push) rdata <= wdata;
    end
  end
endmodule

@@ design/tcch_back.sv @@
// back pipeline: normalize, square root, cordic, conversion
module tcch_back #(
  parameter int CordicSteps = tcch_pkg::DefCordicSteps
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  tcch_pkg::north_t   in_north,
  output logic               out_valid,
  output tcch_pkg::out_word_t out_word
);
  import tcch_pkg::*;

  localparam int Steps = (CordicSteps > AtanLen) ? AtanLen : CordicSteps;
  localparam int SqW = 62;
  localparam int RootBits = 31;
  localparam int Deg90 = 90 * 65536;
  localparam int Deg180 = 180 * 65536;

  // stage a: magnitudes and flags
  logic        va, dega, nxposa, nynega;
  logic [49:0] uxa, uya, uza;
  logic [49:0] orv;
  logic [5:0]  sh;
  // stage b: shifted magnitudes
  logic        vb, degb, nxposb, nynegb;
  logic [30:0] uxb, uyb, uzb;
  // stage c: squares
  logic        vc, degc, nxposc, nynegc;
  logic [30:0] uxc;
  logic [61:0] yy, zz;
  // stage d: sum
  logic        vd, degd, nxposd, nynegd;
  logic [30:0] uxd;
  logic [SqW-1:0] sumd;

  // square root pipeline, one result bit per stage
  logic            sv   [RootBits+1];
  logic            sdeg [RootBits+1];
  logic            snxp [RootBits+1];
  logic            snyn [RootBits+1];
  logic [30:0]     sux  [RootBits+1];
  logic [SqW-1:0]  srem [RootBits+1];
  logic [30:0]     sres [RootBits+1];

  // cordic pipeline
  logic               cv   [Steps+1];
  logic               cdeg [Steps+1];
  logic               cnyn [Steps+1];
  logic signed [34:0] cx   [Steps+1];
  logic signed [34:0] cy   [Steps+1];
  logic signed [24:0] cz   [Steps+1];

  // conversion stages
  logic        ve, dege, nyne;
  logic [24:0] ze;
  logic        vf, degf, nynf;
  logic [31:0] tf;

  always_comb begin
    orv = uxa | uya | uza;
    sh = '0;
    for (int k = 49; k >= 30; k--) begin
      if (sh == '0 && orv[k]) sh = 6'(k - 29);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; ve <= 1'b0; vf <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va <= in_valid; vb <= va; vc <= vb; vd <= vc;
      ve <= cv[Steps]; vf <= ve; out_valid <= vf;
    end
  end

  // shift is the least k with every magnitude >> k at most 2^30
  logic [49:0] sxs, sys, szs;
  logic [5:0]  shf;
  always_comb begin
    shf = sh;
    sxs = uxa >> sh; sys = uya >> sh; szs = uza >> sh;
    if (sh != '0 && (sxs > 50'h40000000 || sys > 50'h40000000 || szs > 50'h40000000))
      shf = sh + 1'b1;
    else if (sh != '0) begin
      // one less may also suffice
      if ((uxa >> (sh - 1'b1)) <= 50'h40000000 && (uya >> (sh - 1'b1)) <= 50'h40000000
          && (uza >> (sh - 1'b1)) <= 50'h40000000)
        shf = sh - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dega <= (in_north.nx == '0) && (in_north.ny == '0) && (in_north.nz == '0);
    nxposa <= !in_north.nx[50] && (in_north.nx != '0);
    nynega <= in_north.ny[50];
    uxa <= 50'(in_north.nx[50] ? -in_north.nx : in_north.nx);
    uya <= 50'(in_north.ny[50] ? -in_north.ny : in_north.ny);
    uza <= 50'(in_north.nz[50] ? -in_north.nz : in_north.nz);

    degb <= dega; nxposb <= nxposa; nynegb <= nynega;
    uxb <= 31'(uxa >> shf); uyb <= 31'(uya >> shf); uzb <= 31'(uza >> shf);

    degc <= degb; nxposc <= nxposb; nynegc <= nynegb; uxc <= uxb;
    yy <= uyb * uyb; zz <= uzb * uzb;

    degd <= degc; nxposd <= nxposc; nynegd <= nynegc; uxd <= uxc;
    sumd <= yy + zz;
  end

  assign sv[0] = vd; assign sdeg[0] = degd; assign snxp[0] = nxposd;
  assign snyn[0] = nynegd; assign sux[0] = uxd; assign srem[0] = sumd;
  assign sres[0] = '0;

  for (genvar g = 0; g < RootBits; g++) begin : g_sqrt
    localparam int B = RootBits - 1 - g;
    logic [SqW:0] trial;
    assign trial = {1'b0, 31'(sres[g]), 31'd0} >> (RootBits - 1 - B)
                   | ((SqW+1)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rst) sv[g+1] <= 1'b0;
      else sv[g+1] <= sv[g];
    end
    always_ff @(posedge clk) begin
      sdeg[g+1] <= sdeg[g]; snxp[g+1] <= snxp[g]; snyn[g+1] <= snyn[g];
      sux[g+1] <= sux[g];
      if ({1'b0, srem[g]} >= trial) begin
        srem[g+1] <= SqW'({1'b0, srem[g]} - trial);
        sres[g+1] <= sres[g] | (31'(1) << B);
      end else begin
        srem[g+1] <= srem[g];
        sres[g+1] <= sres[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else cv[0] <= sv[RootBits];
  end
  always_ff @(posedge clk) begin
    cdeg[0] <= sdeg[RootBits]; cnyn[0] <= snyn[RootBits];
    if (snxp[RootBits]) begin
      cx[0] <= 35'(sres[RootBits]); cy[0] <= 35'(sux[RootBits]); cz[0] <= 25'(Deg90);
    end else begin
      cx[0] <= 35'(sux[RootBits]); cy[0] <= 35'(sres[RootBits]); cz[0] <= '0;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_cordic
    logic signed [34:0] dx, dy;
    logic signed [24:0] da;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    assign da = 25'(atan_lut(5'(i)));
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else cv[i+1] <= cv[i];
    end
    always_ff @(posedge clk) begin
      cdeg[i+1] <= cdeg[i]; cnyn[i+1] <= cnyn[i];
      if (cy[i] > 0) begin
        cx[i+1] <= cx[i] + dx; cy[i+1] <= cy[i] - dy; cz[i+1] <= cz[i] + da;
      end else begin
        cx[i+1] <= cx[i] - dx; cy[i+1] <= cy[i] + dy; cz[i+1] <= cz[i] - da;
      end
    end
  end

  always_ff @(posedge clk) begin
    dege <= cdeg[Steps]; nyne <= cnyn[Steps];
    if (cz[Steps] < 0) ze <= '0;
    else if (cz[Steps] > 25'(Deg180)) ze <= 25'(Deg180);
    else ze <= cz[Steps];

    degf <= dege; nynf <= nyne;
    tf <= (32'(ze) * 32'd100 + 32'd32768) >> 16;

    out_word.degenerate <= degf;
    if (degf) out_word.heading_centideg <= '0;
    else if (nynf) out_word.heading_centideg <= 16'd36000 - 16'(tf);
    else out_word.heading_centideg <= 16'(tf);
  end
endmodule

@@ design/tilt_compensated_compass_heading_top.sv @@
// top level of the tilt compensated compass heading block
// Tilt compensated compass: each pushed word carries a raw magnetometer and an
// accelerometer vector; one result word with the heading in hundredths of a degree
// and a degenerate flag comes out per input word, in order. A new word is taken
// every cycle while full is low: the front pipeline (hard-iron offset and both cross
// products, five stages) feeds a small queue, the back pipeline (normalization,
// 31-stage square root, CordicSteps cordic stages capped at 32, conversion) drains
// it into the output queue. full is raised when the words in flight could overrun
// the output queue, so a stalled consumer never loses a word.
module tilt_compensated_compass_heading_top #(
  parameter int CordicSteps = tcch_pkg::DefCordicSteps
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  tcch_pkg::in_word_t    in_word,
  output logic                  empty,
  input  logic                  pop,
  output tcch_pkg::out_word_t   out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [tcch_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0]           cfg_data
);
  import tcch_pkg::*;

  localparam int Steps = (CordicSteps > AtanLen) ? AtanLen : CordicSteps;
  // front + back latency, all in flight must fit in the output queue
  localparam int Latency = 5 + 1 + 4 + 31 + 1 + Steps + 3;
  localparam int OutDepth = Latency + 4;
  localparam int CntW = $clog2(OutDepth + 1);

  cal_t cal;
  logic accept;
  logic f_valid;
  north_t f_north;
  logic q_empty, q_full;
  north_t q_north;
  logic [$clog2(FifoDepth+1)-1:0] q_count;
  logic b_valid;
  out_word_t b_word;
  logic o_full;
  logic [CntW-1:0] o_count;
  logic [CntW-1:0] inflight;

  assign cfg_ready = 1'b1;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal.min_x <= -16'sd190; cal.min_y <= -16'sd850; cal.min_z <= 16'sd3460;
      cal.max_x <= 16'sd2100; cal.max_y <= 16'sd1280; cal.max_z <= 16'sd3800;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegMinX: cal.min_x <= cfg_data;
        RegMinY: cal.min_y <= cfg_data;
        RegMinZ: cal.min_z <= cfg_data;
        RegMaxX: cal.max_x <= cfg_data;
        RegMaxY: cal.max_y <= cfg_data;
        RegMaxZ: cal.max_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // credit count: words accepted but not yet popped
  assign accept = push && !full;
  assign full = (inflight >= CntW'(OutDepth));
  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= inflight + (accept ? 1'b1 : 1'b0) - ((pop && !empty) ? 1'b1 : 1'b0);
  end

  tcch_front u_front (
    .clk, .rst, .in_valid(accept), .in_word, .cal,
    .out_valid(f_valid), .out_north(f_north)
  );

  // mid queue: back pipeline never stalls, so it drains every cycle
  tcch_fifo #(.Width($bits(north_t)), .Depth(FifoDepth)) u_midq (
    .clk, .rst, .push(f_valid), .wdata(f_north), .full(q_full),
    .pop(!q_empty), .empty(q_empty), .rdata(q_north), .count(q_count)
  );

  tcch_back #(.CordicSteps(CordicSteps)) u_back (
    .clk, .rst, .in_valid(!q_empty), .in_north(q_north),
    .out_valid(b_valid), .out_word(b_word)
  );

  tcch_fifo #(.Width($bits(out_word_t)), .Depth(OutDepth)) u_outq (
    .clk, .rst, .push(b_valid), .wdata(b_word), .full(o_full),
    .pop(pop), .empty(empty), .rdata(out_word), .count(o_count)
  );

  // output queue never overflows thanks to the credit count, mid queue never fills
  assert property (@(posedge clk) disable iff (rst) b_valid |-> !o_full)
    else $error("output queue overrun");
  assert property (@(posedge clk) disable iff (rst) f_valid |-> !q_full)
    else $error("mid queue overrun");
  assert property (@(posedge clk) disable iff (rst) o_count <= inflight)
    else $error("more results than words in flight");
  assert property (@(posedge clk) disable iff (rst) q_count <= 1)
    else $error("mid queue backed up");
endmodule
